>>> rtl/pirl_pkg.sv
// Package for the positional insert/remove list.
// Holds the beat payload structs and the command codes; no dependencies.
package pirl_pkg;

  // Stored word and the fixed width of the reported count field
  typedef logic signed [31:0] word_t;
  typedef logic [4:0]         count_field_t;

  // Command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // Input beat
  typedef struct packed {
    logic       command;
    word_t      value;
    logic [7:0] position;
  } in_t;

  // Result beat
  typedef struct packed {
    word_t        removed_value;
    logic         empty_error;
    logic         full_error;
    count_field_t entry_count;
    word_t        back_value;
  } out_t;

endpackage

>>> rtl/pirl_cells.sv
// List storage for the positional insert/remove list: a row of word cells
// with per-cell shift muxes, the element count and the result logic.
// Depends on pirl_pkg.
module pirl_cells #(
  parameter int DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  pirl_pkg::in_t  item,
  output pirl_pkg::out_t result
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

  // Cells are kept back-first: cell 0 holds the back element,
  // cell count-1 holds the front element.
  pirl_pkg::word_t  cell_r   [DEPTH];
  pirl_pkg::word_t  cell_nxt [DEPTH];
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  logic             is_insert;
  logic             past_end;
  logic             full;
  logic             empty;
  logic             do_insert;
  logic             do_remove;
  logic [CNT_W-1:0] ins_pos;
  logic [CNT_W-1:0] rem_pos;
  logic [CNT_W-1:0] ins_cell;
  logic [CNT_W-1:0] rem_cell;

  // Decode the operation and map list positions to cell numbers
  always_comb begin
    is_insert = (item.command == pirl_pkg::CMD_INSERT);
    past_end  = (CMP_W'(item.position) >= CMP_W'(count_r));
    full      = (count_r == CNT_W'(DEPTH));
    empty     = (count_r == '0);
    do_insert = is_insert && !full;
    do_remove = !is_insert && !empty;
    ins_pos   = past_end ? count_r : CNT_W'(item.position);
    rem_pos   = past_end ? '0 : CNT_W'(item.position);
    ins_cell  = count_r - ins_pos;
    rem_cell  = count_r - rem_pos - CNT_W'(1);
  end

  // Per-cell shift muxes
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    localparam int LO = (k == 0) ? 0 : k - 1;
    localparam int HI = (k == DEPTH - 1) ? k : k + 1;

    always_comb begin
      cell_nxt[k] = cell_r[k];
      if (do_insert) begin
        if (CNT_W'(k) == ins_cell) begin
          cell_nxt[k] = item.value;
        end else if (CNT_W'(k) > ins_cell) begin
          cell_nxt[k] = cell_r[LO];
        end
      end else if (do_remove) begin
        if (CNT_W'(k) >= rem_cell) begin
          cell_nxt[k] = cell_r[HI];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (step) begin
        cell_r[k] <= cell_nxt[k];
      end
    end
  end

  // Count update
  always_comb begin
    count_nxt = count_r;
    if (do_insert) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_remove) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (step) begin
      count_r <= count_nxt;
    end
  end

  // Result fields
  always_comb begin
    result.removed_value = do_remove ? cell_r[rem_cell[IDX_W-1:0]] : '0;
    result.empty_error   = !is_insert && empty;
    result.full_error    = is_insert && full;
    result.entry_count   = pirl_pkg::count_field_t'(count_nxt);
    result.back_value    = (count_nxt != '0) ? cell_nxt[0] : '0;
  end

endmodule

>>> rtl/positional_insert_remove_list.sv
// Positional insert/remove list, top level: input register, list cells
// and result register with valid/ready handshakes. Depends on pirl_pkg, pirl_cells.
//
// Usage:
//   in_*  channel carries one command beat: insert value at position, or
//         remove the value at position. Positions at or past the count go
//         to the back for insert and to the front for remove.
//   out_* channel returns exactly one result beat per command: removed
//         value, empty/full error flags, count and back value after it.
//   The input register holds an accepted beat; it passes through the cells
//   into the result register once that register is free or draining.
//   Throughput: one beat per cycle while out_ready stays high, set by the single
//   register-to-register pass through the cell shift muxes.
//   Reset (rst_n low, synchronous) empties the list and drops any beat in
//   flight; in_ready is high from the first cycle after reset.
//   When the receiver stalls, the result register holds its beat and the
//   input register takes one more beat; in_ready then drops until
//   out_ready returns.
module positional_insert_remove_list #(
  parameter int DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  pirl_pkg::in_t  in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output pirl_pkg::out_t out_item
);

  logic           in_valid_r;
  pirl_pkg::in_t  in_r;
  logic           out_valid_r;
  pirl_pkg::out_t out_r;
  pirl_pkg::out_t result;
  logic           advance;

  // Move a beat into the result register when it is free or draining
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  pirl_cells #(
    .DEPTH (DEPTH)
  ) u_cells (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (in_r),
    .result (result)
  );

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_item;
    end
    if (advance) begin
      out_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

>>> rtl/pirl_checker.sv
// Port-level checks for the positional insert/remove list, bound to the top.
// Depends on pirl_pkg and positional_insert_remove_list.
module pirl_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input pirl_pkg::in_t  in_item,
  input logic           out_valid,
  input logic           out_ready,
  input pirl_pkg::out_t out_item
);

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result beat changed while stalled");

  // Reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Empty error means an empty list and nothing removed
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.empty_error |->
      out_item.entry_count == '0 && out_item.removed_value == '0 &&
      out_item.back_value == '0 && !out_item.full_error)
    else $error("empty error with inconsistent fields");

  // A dropped insert removes nothing and leaves a nonempty list
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.full_error |->
      out_item.removed_value == '0 && !out_item.empty_error)
    else $error("full error with inconsistent fields");

endmodule

bind positional_insert_remove_list pirl_checker u_pirl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
